@@ src/twine_block_cipher_top_assert.svh @@
// assertion macros shared by the cipher rtl
// included by modules that check their own sequencing; no other dependencies
`ifndef TWINE_BLOCK_CIPHER_TOP_ASSERT_SVH
`define TWINE_BLOCK_CIPHER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property, checked every clock edge outside reset
`define TWC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// implication from a condition to a consequence in the next cycle
`define TWC_ASSERT_NEXT(lbl, clk, rstn, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define TWC_ASSERT(lbl, clk, rstn, prop, msg)
`define TWC_ASSERT_NEXT(lbl, clk, rstn, cond, conseq, msg)
`endif

`endif

@@ src/twc_pkg.sv @@
// shared constants, types and round functions for the twine-style cipher
// no dependencies; used by every rtl file of the block except twc_ram
`timescale 1ns / 1ps

package twc_pkg;

    // round key store geometry
    localparam int ROUND_COUNT = 36;
    localparam int RK_W        = 32;
    localparam int RK_AW       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [RK_AW-1:0] LAST_STEP = RK_AW'(ROUND_COUNT - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 2'd2;

    localparam logic KEY_SIZE_80  = 1'b0;
    localparam logic KEY_SIZE_128 = 1'b1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [7:0] CON_INIT = 8'h01;
    localparam logic [7:0] CON_POLY = 8'h1B;

    // nibble h moves to position PERM[h]
    localparam logic [3:0] PERM [16] = '{
        4'd5, 4'd0, 4'd1, 4'd4, 4'd7, 4'd12, 4'd3, 4'd8,
        4'd13, 4'd6, 4'd9, 4'd2, 4'd15, 4'd10, 4'd11, 4'd14
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROUND,
        ST_DONE
    } core_state_t;

    // round key memory write port
    typedef struct packed {
        logic             we;
        logic [RK_AW-1:0] addr;
        logic [RK_W-1:0]  data;
    } rk_wr_t;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h0;
            4'h2: y = 4'hF;
            4'h3: y = 4'hA;
            4'h4: y = 4'h2;
            4'h5: y = 4'hB;
            4'h6: y = 4'h9;
            4'h7: y = 4'h5;
            4'h8: y = 4'h8;
            4'h9: y = 4'h3;
            4'hA: y = 4'hD;
            4'hB: y = 4'h7;
            4'hC: y = 4'h1;
            4'hD: y = 4'hE;
            4'hE: y = 4'h6;
            default: y = 4'h4;
        endcase
        return y;
    endfunction

    // nibble 0 sits in the top bits of the block
    function automatic logic [63:0] f_layer(input logic [63:0] blk, input logic [RK_W-1:0] rk);
        logic [63:0] y;
        y = blk;
        for (int j = 0; j < 8; j++) begin
            y[59 - 8*j -: 4] = blk[59 - 8*j -: 4] ^ sbox(blk[63 - 8*j -: 4] ^ rk[31 - 4*j -: 4]);
        end
        return y;
    endfunction

    function automatic logic [63:0] shuffle(input logic [63:0] blk);
        logic [63:0] y;
        y = '0;
        for (int h = 0; h < 16; h++) begin
            y[63 - 4*int'(PERM[h]) -: 4] = blk[63 - 4*h -: 4];
        end
        return y;
    endfunction

    function automatic logic [63:0] inv_shuffle(input logic [63:0] blk);
        logic [63:0] y;
        y = '0;
        for (int h = 0; h < 16; h++) begin
            y[63 - 4*h -: 4] = blk[63 - 4*int'(PERM[h]) -: 4];
        end
        return y;
    endfunction

    // one step of the shared round unit
    function automatic logic [63:0] round_step(input logic [63:0] blk,
                                               input logic [RK_W-1:0] rk,
                                               input logic op,
                                               input logic first,
                                               input logic last);
        logic [63:0] x;
        if (op == OP_ENCRYPT) begin
            x = f_layer(blk, rk);
            if (!last) begin
                x = shuffle(x);
            end
        end else begin
            x = first ? blk : inv_shuffle(blk);
            x = f_layer(x, rk);
        end
        return x;
    endfunction

    // one byte step of the 80-bit schedule; byte k sits at [127-8k -: 8]
    function automatic logic [127:0] key_byte_step(input logic [127:0] w, input logic [7:0] con);
        logic [7:0]   v;
        logic [7:0]   t;
        logic [127:0] m;
        logic [127:0] y;
        v = w[119:112] ^ w[103:96] ^ w[95:88] ^ w[79:72] ^ w[23:16] ^ w[15:8] ^ con;
        t = {sbox(v[7:4]), sbox(v[3:0])};
        m = w;
        m[127:120] = w[127:120] ^ t;
        // bytes move down by one, last byte takes the new byte 0 (old byte 1)
        y = {m[119:0], m[119:112]};
        return y;
    endfunction

    function automatic logic [127:0] key_round(input logic [127:0] w, input logic [7:0] con);
        logic [127:0] x;
        x = w;
        for (int j = 0; j < 4; j++) begin
            x = key_byte_step(x, con);
        end
        return x;
    endfunction

    function automatic logic [7:0] con_next(input logic [7:0] con);
        return {con[6:0], 1'b0} ^ (con[7] ? CON_POLY : 8'h00);
    endfunction

endpackage

@@ src/twc_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module twc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/twc_key_sched.sv @@
// key registers and round key expansion, one round key per cycle
// depends on twc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "twine_block_cipher_top_assert.svh"

module twc_key_sched (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twc_pkg::CFG_W-1:0]      cfg_wdata,
    output twc_pkg::rk_wr_t                rk_wr,
    output logic                           keys_ready
);

    logic [63:0]               key_high_reg;
    logic [63:0]               key_low_reg;
    logic                      key_size_reg;
    logic                      load_reg;
    logic                      busy_reg;
    logic [twc_pkg::RK_AW-1:0] idx_reg;
    logic [127:0]              w_reg;
    logic [127:0]              w_next;
    logic [7:0]                con_reg;
    logic                      hit;
    logic [twc_pkg::RK_W-1:0]  rk128;
    logic [twc_pkg::RK_W-1:0]  rk80;

    // a write to a known register restarts the expansion
    always_comb begin
        unique case (cfg_index) inside
            twc_pkg::REG_KEY_HIGH,
            twc_pkg::REG_KEY_LOW,
            twc_pkg::REG_KEY_SIZE: hit = cfg_we;
            default:               hit = 1'b0;
        endcase
    end

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            key_size_reg <= twc_pkg::KEY_SIZE_128;
        end else if (cfg_we) begin
            if (cfg_index == twc_pkg::REG_KEY_HIGH) begin
                key_high_reg <= cfg_wdata;
            end
            if (cfg_index == twc_pkg::REG_KEY_LOW) begin
                key_low_reg <= cfg_wdata;
            end
            if (cfg_index == twc_pkg::REG_KEY_SIZE) begin
                key_size_reg <= cfg_wdata[0];
            end
        end
    end

    // schedule datapath
    assign w_next = twc_pkg::key_round(w_reg, con_reg);
    assign rk80   = {w_next[119:112], w_next[103:96], w_next[95:88], w_next[87:80]};
    assign rk128  = {key_high_reg[47:40], key_high_reg[39:32], key_low_reg[31:24],
                     key_low_reg[7:0]};

    // expansion sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b1;
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (hit) begin
            load_reg <= 1'b1;
            busy_reg <= 1'b1;
        end else if (load_reg) begin
            load_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (busy_reg) begin
            if (idx_reg == twc_pkg::LAST_STEP) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + twc_pkg::RK_AW'(1);
            end
        end
    end

    // work bytes and round constant
    always_ff @(posedge aclk) begin
        if (load_reg) begin
            w_reg   <= {key_high_reg, key_low_reg[63:48], 48'h0};
            con_reg <= twc_pkg::CON_INIT;
        end else if (busy_reg) begin
            w_reg   <= w_next;
            con_reg <= twc_pkg::con_next(con_reg);
        end
    end

    always_comb begin
        rk_wr.we   = busy_reg && !load_reg;
        rk_wr.addr = idx_reg;
        rk_wr.data = (key_size_reg == twc_pkg::KEY_SIZE_128) ? rk128 : rk80;
    end

    assign keys_ready = !busy_reg;

    `TWC_ASSERT(a_wr_addr_range, aclk, aresetn,
                rk_wr.we |-> (rk_wr.addr <= twc_pkg::LAST_STEP),
                "round key write beyond store")
    `TWC_ASSERT_NEXT(a_load_then_busy, aclk, aresetn, load_reg && !hit,
                     busy_reg && idx_reg == '0,
                     "expansion did not start at entry zero")

endmodule

@@ src/twc_round_core.sv @@
// round sequencer and shared round unit, one round per cycle
// depends on twc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "twine_block_cipher_top_assert.svh"

module twc_round_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           keys_ready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic                           s_op,
    input  logic [63:0]                    s_block,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_block,
    output logic [twc_pkg::RK_AW-1:0]      rk_raddr,
    input  logic [twc_pkg::RK_W-1:0]       rk_rdata
);

    twc_pkg::core_state_t       state_reg;
    twc_pkg::core_state_t       state_next;
    logic [twc_pkg::RK_AW-1:0]  step_reg;
    logic [twc_pkg::RK_AW-1:0]  fetch_step;
    logic                       op_reg;
    logic [63:0]                blk_reg;
    logic [63:0]                blk_round;
    logic                       out_valid_reg;
    logic [63:0]                out_data_reg;
    logic                       in_ready;
    logic                       load_out;
    logic                       accept;
    logic                       last_step;

    assign accept    = s_tvalid && in_ready;
    assign last_step = (step_reg == twc_pkg::LAST_STEP);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            twc_pkg::ST_IDLE:  if (accept) state_next = twc_pkg::ST_FETCH;
            twc_pkg::ST_FETCH: state_next = twc_pkg::ST_ROUND;
            twc_pkg::ST_ROUND: if (last_step) state_next = twc_pkg::ST_DONE;
            twc_pkg::ST_DONE:  if (!out_valid_reg || m_tready) state_next = twc_pkg::ST_IDLE;
            default:           state_next = twc_pkg::ST_IDLE;
        endcase
    end

    // state outputs and round key fetch address
    always_comb begin
        in_ready   = 1'b0;
        load_out   = 1'b0;
        fetch_step = step_reg;
        unique case (state_reg)
            twc_pkg::ST_IDLE:  in_ready = keys_ready;
            twc_pkg::ST_FETCH: fetch_step = '0;
            twc_pkg::ST_ROUND: begin
                if (!last_step) begin
                    fetch_step = step_reg + twc_pkg::RK_AW'(1);
                end
            end
            twc_pkg::ST_DONE:  load_out = !out_valid_reg || m_tready;
            default:           in_ready = 1'b0;
        endcase
        rk_raddr = (op_reg == twc_pkg::OP_DECRYPT) ? (twc_pkg::LAST_STEP - fetch_step)
                                                   : fetch_step;
    end

    // shared round unit
    assign blk_round = twc_pkg::round_step(blk_reg, rk_rdata, op_reg,
                                           step_reg == '0, last_step);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= twc_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == twc_pkg::ST_FETCH) begin
                step_reg <= '0;
            end else if (state_reg == twc_pkg::ST_ROUND && !last_step) begin
                step_reg <= step_reg + twc_pkg::RK_AW'(1);
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working block and result word
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_op;
            blk_reg <= s_block;
        end else if (state_reg == twc_pkg::ST_ROUND) begin
            blk_reg <= blk_round;
        end
        if (load_out) begin
            out_data_reg <= blk_reg;
        end
    end

    assign s_tready = in_ready;
    assign m_tvalid = out_valid_reg;
    assign m_block  = out_data_reg;

    `TWC_ASSERT(a_step_range, aclk, aresetn, (state_reg == twc_pkg::ST_ROUND) |-> (step_reg <= twc_pkg::LAST_STEP), "round step out of range")
    `TWC_ASSERT(a_valid_from_done, aclk, aresetn, $rose(out_valid_reg) |-> $past(state_reg == twc_pkg::ST_DONE), "result raised outside done state")
    `TWC_ASSERT_NEXT(a_fetch_to_round, aclk, aresetn, state_reg == twc_pkg::ST_FETCH, state_reg == twc_pkg::ST_ROUND && step_reg == '0, "rounds did not start at step zero")

endmodule

@@ src/twine_block_cipher_top.sv @@
// top level of the twine-style 64-bit block cipher
// uses twc_pkg, twc_ram, twc_key_sched and twc_round_core
//
// usage:
//   - keys are written through cfg_we / cfg_index / cfg_wdata: index 0 is
//     key_high, 1 is key_low, 2 is key_size (bit 0, 0 = 80-bit schedule,
//     1 = 128-bit path); other indexes are ignored
//   - each key write expands the 36 round keys again into a small ram, one
//     round key per cycle; s_tready stays low meanwhile
//   - after reset the same expansion runs on the reset keys
//     (all zero, 128-bit path) before the first word is taken
//   - s_tdata carries the 64-bit block, s_tuser the operation (0 encrypt,
//     1 decrypt); m_tdata returns the 64-bit result
//   - each word passes a fetch state for the first round key read, the round
//     state of the shared round unit (one round key read per cycle from the
//     ram) and a done state that loads the result register, raising m_tvalid
//   - the next word can be accepted the cycle after the result is loaded, if
//     keys_ready is high; a word can be taken while the previous result waits
//   - if m_tready is held low the finished block waits in the core and no
//     further word is accepted until the result register frees up
`timescale 1ns / 1ps

module twine_block_cipher_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [twc_pkg::CFG_W-1:0]     cfg_wdata,
    // input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // block_in[63:0]
    input  logic                          s_tuser,   // operation[0]
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata    // block_out[63:0]
);

    twc_pkg::rk_wr_t             rk_wr;
    logic                        keys_ready;
    logic [twc_pkg::RK_AW-1:0]   rk_raddr;
    logic [twc_pkg::RK_W-1:0]    rk_rdata;

    // key registers and schedule
    twc_key_sched u_key_sched (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .rk_wr      (rk_wr),
        .keys_ready (keys_ready)
    );

    // round key store
    twc_ram #(
        .WIDTH (twc_pkg::RK_W),
        .DEPTH (twc_pkg::ROUND_COUNT)
    ) u_rk_ram (
        .aclk  (aclk),
        .we    (rk_wr.we),
        .waddr (rk_wr.addr),
        .wdata (rk_wr.data),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    // round sequencer and datapath
    twc_round_core u_round_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .keys_ready (keys_ready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_op       (s_tuser),
        .s_block    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_block    (m_tdata),
        .rk_raddr   (rk_raddr),
        .rk_rdata   (rk_rdata)
    );

endmodule

@@ bench/twc_checker.sv @@
// result checker for the twine-style block cipher: tracks key writes, predicts each word
// and compares the result stream in order; depends on twc_pkg for register, op and schedule constants
`timescale 1ns / 1ps

module twc_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [twc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [twc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // block_in[63:0]
    input  logic                          s_tuser,   // operation[0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [63:0]                   m_tdata,   // block_out[63:0]
    output int                            errors,
    output int                            pending,
    output int                            checked
);
    import twc_pkg::*;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h0, 4'hF, 4'hA, 4'h2, 4'hB, 4'h9, 4'h5,
        4'h8, 4'h3, 4'hD, 4'h7, 4'h1, 4'hE, 4'h6, 4'h4
    };
    // destination of nibble h after one round
    localparam int NIBBLE_DEST [16] = '{5, 0, 1, 4, 7, 12, 3, 8, 13, 6, 9, 2, 15, 10, 11, 14};

    logic [63:0] key_high_q = '0;
    logic [63:0] key_low_q  = '0;
    logic        key_size_q = KEY_SIZE_128;
    logic [31:0] round_keys [ROUND_COUNT];
    logic [63:0] expected_blocks [$];
    int          fail_count = 0;
    int          match_count = 0;

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    // rebuild all round keys from the current key registers
    function automatic void expand_round_keys();
        logic [7:0]  w [16];
        logic [7:0]  con;
        logic [7:0]  v;
        logic [31:0] word;
        for (int i = 0; i < 8; i++) begin
            w[i]     = key_high_q[63 - 8*i -: 8];
            w[8 + i] = key_low_q[63 - 8*i -: 8];
        end
        if (key_size_q == KEY_SIZE_80) begin
            for (int i = 10; i < 16; i++) w[i] = 8'h00;
            con = CON_INIT;
            for (int r = 0; r < ROUND_COUNT; r++) begin
                for (int j = 0; j < 4; j++) begin
                    v = w[1] ^ w[3] ^ w[4] ^ w[6] ^ w[13] ^ w[14] ^ con;
                    w[0] = w[0] ^ {SBOX[v[7:4]], SBOX[v[3:0]]};
                    for (int k = 0; k < 15; k++) w[k] = w[k + 1];
                    w[15] = w[0];
                end
                round_keys[r] = {w[1], w[3], w[4], w[5]};
                con = {con[6:0], 1'b0} ^ (con[7] ? CON_POLY : 8'h00);
            end
        end else begin
            word = {w[2], w[3], w[12], w[15]};
            for (int r = 0; r < ROUND_COUNT; r++) round_keys[r] = word;
        end
    endfunction

    // keyed s-box of each even nibble folded into its odd neighbor
    function automatic logic [63:0] feistel_mix(input logic [63:0] s, input logic [31:0] rk);
        logic [63:0] y;
        logic [3:0]  a;
        y = s;
        for (int j = 0; j < 8; j++) begin
            a = s[63 - 8*j -: 4] ^ rk[31 - 4*j -: 4];
            y[59 - 8*j -: 4] = s[59 - 8*j -: 4] ^ SBOX[a];
        end
        return y;
    endfunction

    function automatic logic [63:0] nibble_shuffle(input logic [63:0] s, input logic backward);
        logic [63:0] y;
        y = '0;
        for (int h = 0; h < 16; h++) begin
            if (!backward) y[63 - 4*NIBBLE_DEST[h] -: 4] = s[63 - 4*h -: 4];
            else y[63 - 4*h -: 4] = s[63 - 4*NIBBLE_DEST[h] -: 4];
        end
        return y;
    endfunction

    function automatic logic [63:0] cipher_block(input logic op, input logic [63:0] blk);
        logic [63:0] s;
        s = blk;
        if (op == OP_ENCRYPT) begin
            for (int r = 0; r < ROUND_COUNT - 1; r++)
                s = nibble_shuffle(feistel_mix(s, round_keys[r]), 1'b0);
            s = feistel_mix(s, round_keys[ROUND_COUNT - 1]);
        end else begin
            s = feistel_mix(s, round_keys[ROUND_COUNT - 1]);
            for (int r = ROUND_COUNT - 2; r >= 0; r--)
                s = feistel_mix(nibble_shuffle(s, 1'b1), round_keys[r]);
        end
        return s;
    endfunction

    initial expand_round_keys();

    // watch key writes and both word channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            key_high_q = '0;
            key_low_q  = '0;
            key_size_q = KEY_SIZE_128;
            expand_round_keys();
            expected_blocks.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_HIGH: key_high_q = cfg_wdata;
                    REG_KEY_LOW:  key_low_q  = cfg_wdata;
                    REG_KEY_SIZE: key_size_q = cfg_wdata[0];
                    default: ;
                endcase
                expand_round_keys();
            end
            if (s_tvalid && s_tready)
                expected_blocks.push_back(cipher_block(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result word %h with nothing outstanding", $realtime, m_tdata);
                    fail_count++;
                end else begin
                    if (m_tdata !== expected_blocks[0]) begin
                        if (fail_count < 10)
                            $display("%0t: block_out mismatch, expected %h got %h",
                                     $realtime, expected_blocks[0], m_tdata);
                        fail_count++;
                    end else begin
                        match_count++;
                    end
                    void'(expected_blocks.pop_front());
                end
            end
        end
        errors  <= fail_count;
        pending <= expected_blocks.size();
        checked <= match_count;
    end

endmodule

@@ bench/tb.sv @@
// stimulus and verdict for the twine-style block cipher
// drives key writes and blocks into twine_block_cipher_top; twc_checker does the checking
`timescale 1ns / 1ps

module tb;
    import twc_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 130;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 45;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // block_in[63:0]
    logic                 s_tuser   = 1'b0; // operation[0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // block_out[63:0]

    int errors;
    int pending;
    int checked;
    int cycle_count = 0;
    int n_encrypt   = 0;
    int n_decrypt   = 0;
    bit stalls_on   = 1'b1;

    twine_block_cipher_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    twc_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side back-pressure in short bursts
    always begin
        @(negedge aclk);
        if (stalls_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // present one word, return at the falling edge after it is taken
    task automatic send_word(input logic op, input logic [63:0] blk);
        if (stalls_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= blk;
        if (op == OP_ENCRYPT) n_encrypt++;
        else n_decrypt++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // one register write per cycle; caller drops cfg_we afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    function automatic logic [63:0] random_block();
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] phase_key(input int phase);
        if (phase == 0 || phase == 3) return 64'h0;
        if (phase == 1 || phase == 2) return '1;
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] patterns [6];
        logic        size_sel;
        patterns = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed words on the reset key (all zero, 128-bit path)
        for (int i = 0; i < 6; i++) begin
            send_word(OP_ENCRYPT, patterns[i]);
            send_word(OP_DECRYPT, patterns[i]);
        end

        for (int p = 0; p < PHASES; p++) begin
            // block is idle once every result is back
            s_tvalid <= 1'b0;
            while (pending != 0) @(negedge aclk);
            repeat (4) @(negedge aclk);

            // no idling in the last phase, none in phase 3 either
            stalls_on = (p != 3) && (p != PHASES - 1);
            size_sel  = (p < 2) ? KEY_SIZE_80 :
                        (p < 4) ? KEY_SIZE_128 : logic'(p[0]);
            write_reg(REG_KEY_HIGH, phase_key(p));
            write_reg(REG_KEY_LOW, phase_key(p));
            // upper bits of key_size carry noise
            write_reg(REG_KEY_SIZE,
                      ({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFFE) | 64'(size_sel));
            if ($urandom_range(0, 1)) write_reg(REG_UNUSED, {$urandom, $urandom});
            cfg_we <= 1'b0;

            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(logic'($urandom_range(0, 1)), random_block());
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("tb: %0d blocks checked (%0d encrypt, %0d decrypt) under %0d key settings",
                 checked, n_encrypt, n_decrypt, PHASES + 1);
        $display("tb: covered both key schedules, all-zero and all-one keys, stalls on both sides");
        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
